[design/roulette_wheel_selector_core_assert.svh]
// ----------------------------------------------------------------------------
// Roulette wheel selector assertion macros
// Property templates shared by the selector's checking code.
// ----------------------------------------------------------------------------
`ifndef ROULETTE_WHEEL_SELECTOR_CORE_ASSERT_SVH
`define ROULETTE_WHEEL_SELECTOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RWS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RWS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/rws_pkg.sv]
// ----------------------------------------------------------------------------
// Roulette wheel selector package
// Sizes and the draw request passed from the list builder to the search.
// ----------------------------------------------------------------------------
package rws_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int WEIGHT_BITS = 16;
	localparam int ID_BITS     = 10;
	localparam int FRAC_BITS   = 16;

	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int SUM_W  = WEIGHT_BITS + IDX_W;
	localparam int PROD_W = SUM_W + FRAC_BITS;
	localparam int MEM_W  = SUM_W + ID_BITS;

	// Draw request: issued on the request marked last.
	typedef struct packed {
		logic                 valid;
		logic [IDX_W-1:0]     hi_idx;   // index of the last stored entry
		logic [SUM_W-1:0]     total;    // sum of all stored weights
		logic [FRAC_BITS-1:0] frac;     // random fraction, Q0.16
		logic                 ovf;      // some request of the list was dropped
	} draw_req_t;

endpackage

[design/rws_ram.sv]
// ----------------------------------------------------------------------------
// Roulette wheel selector RAM
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module rws_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/rws_search.sv]
// ----------------------------------------------------------------------------
// Roulette wheel selector search
// Scales the total by the fraction and binary-searches the prefix-sum RAM.
// ----------------------------------------------------------------------------
module rws_search import rws_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  draw_req_t          req,
	input  logic [MEM_W-1:0]   rd_data,
	output logic               rd_en,
	output logic [IDX_W-1:0]   rd_addr,
	output logic               busy,
	output logic               done,
	output logic [ID_BITS-1:0] chosen_id,
	output logic               overflow
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_PROBE = 3'd2;
	localparam logic [2:0] S_CMP   = 3'd3;
	localparam logic [2:0] S_FETCH = 3'd4;

	logic [2:0]           state_q;
	logic [IDX_W-1:0]     lo_q;
	logic [IDX_W-1:0]     hi_q;
	logic [IDX_W-1:0]     mid_q;
	logic [SUM_W-1:0]     total_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic                 ovf_q;
	logic [PROD_W-1:0]    target_q;
	logic                 done_q;
	logic [ID_BITS-1:0]   chosen_q;
	logic                 ovf_out_q;

	logic [IDX_W-1:0]     mid;
	logic [SUM_W-1:0]     rd_sum;
	logic                 at_or_above;

	assign mid         = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_sum      = rd_data[MEM_W-1 -: SUM_W];
	assign at_or_above = (PROD_W'(rd_sum) << FRAC_BITS) >= target_q;

	assign rd_en   = (state_q == S_PROBE);
	assign rd_addr = (lo_q < hi_q) ? mid : lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					state_q <= (lo_q < hi_q) ? S_CMP : S_FETCH;
				end
				S_CMP: begin
					state_q <= S_PROBE;
				end
				S_FETCH: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath: capture the request, form the target, narrow [lo, hi].
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			lo_q    <= '0;
			hi_q    <= req.hi_idx;
			total_q <= req.total;
			frac_q  <= req.frac;
			ovf_q   <= req.ovf;
		end
		if (state_q == S_MUL) begin
			target_q <= PROD_W'(total_q) * PROD_W'(frac_q);
		end
		if (state_q == S_PROBE) begin
			mid_q <= mid;
		end
		if (state_q == S_CMP) begin
			if (at_or_above) begin
				hi_q <= mid_q;
			end else begin
				lo_q <= mid_q + 1'b1;
			end
		end
		if (state_q == S_FETCH) begin
			chosen_q  <= rd_data[ID_BITS-1:0];
			ovf_out_q <= ovf_q;
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign chosen_id = chosen_q;
	assign overflow  = ovf_out_q;

endmodule

[design/roulette_wheel_selector_core.sv]
// Sequence: a request without last is stored as it is accepted; after a last request
//   the search runs the multiply, k search steps of probe and compare, and a fetch,
//   then raises done; k is at most ceil(log2(n)) over n <= 64 stored entries.
// Throughput: one request per cycle while a list loads and the search is idle; busy
//   holds during the draw (multiply and read-compare loop on the RAM read port).
// Reset: arst_n clears the list count, total, drop flag and search control; the
//   RAM is not cleared. The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
// Roulette wheel selector core
// Builds a prefix-sum list in RAM and draws one entry by fitness proportion.
// ----------------------------------------------------------------------------
`include "roulette_wheel_selector_core_assert.svh"

module roulette_wheel_selector_core import rws_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [WEIGHT_BITS-1:0] weight,
	input  logic [ID_BITS-1:0]     element_id,
	input  logic                   last,
	input  logic [FRAC_BITS-1:0]   random_fraction,
	output logic                   done,
	output logic [ID_BITS-1:0]     chosen_id,
	output logic                   overflow
);

	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  total_q;
	logic              dropped_q;

	logic              accept;
	logic              room;
	logic [SUM_W-1:0]  sum_new;
	logic              wr_en;
	logic [MEM_W-1:0]  wr_data;
	draw_req_t         req;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [MEM_W-1:0]  rd_data;

	// A request is taken whenever the search is idle.
	assign accept  = start & ~busy;
	assign room    = (count_q < CNT_W'(MAX_ENTRIES));
	assign sum_new = total_q + SUM_W'(weight);

	// Store the new prefix sum and id at the next free entry; drop when full.
	assign wr_en   = accept & room;
	assign wr_data = {sum_new, element_id};

	// On the last request hand the finished list to the search. The entry
	// written this same cycle is in RAM before the first search read.
	always_comb begin
		req.valid  = accept & last;
		req.hi_idx = room ? count_q[IDX_W-1:0] : IDX_W'(MAX_ENTRIES - 1);
		req.total  = room ? sum_new : total_q;
		req.frac   = random_fraction;
		req.ovf    = dropped_q | ~room;
	end

	// List bookkeeping: advance on a stored request, flag a dropped one, clear once the draw is issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			total_q   <= '0;
			dropped_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				count_q   <= '0;
				total_q   <= '0;
				dropped_q <= 1'b0;
			end else if (room) begin
				count_q <= count_q + 1'b1;
				total_q <= sum_new;
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

	rws_ram #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (MEM_W)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	rws_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rd_data   (rd_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.busy      (busy),
		.done      (done),
		.chosen_id (chosen_id),
		.overflow  (overflow)
	);

	`RWS_ASSERT_NEXT(a_draw_goes_busy, accept && last, busy, "draw did not start")
	`RWS_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result without a draw")
	`RWS_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`RWS_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_ENTRIES), "list count out of range")

endmodule
